>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the dither core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen on a rising edge
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_AT(label, !(cond), msg)

`endif

>>> rtl/core/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// types, constants and helpers shared by the error diffusion dither core
// ----------------------------------------------------------------------------
package edd_pkg;

	// defaults for the top level parameters
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int FRAC_BITS_DEF = 16;

	// weight format: Q.27, jitter product and split point for the multipliers
	localparam int WFRAC    = 27;
	localparam int WT_W     = 36;
	localparam int WT_SPLIT = 18;
	localparam int JP_W     = 33;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IMG_W_W    = 11;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH    = 2'd0,
		CFG_SERPENTINE_OFF = 2'd1,
		CFG_FIXED_WEIGHTS  = 2'd2,
		CFG_JITTER_SCALE   = 2'd3
	} edd_cfg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_DIFF,
		ST_MUL,
		ST_UPD,
		ST_WLAST
	} edd_state_t;

	// channel payloads
	typedef struct packed {
		logic               frame_start;
		logic [15:0]        sample;
		logic signed [15:0] jitter_a;
		logic signed [15:0] jitter_b;
	} edd_in_t;

	typedef struct packed {
		logic pixel_bit;
		logic row_end;
	} edd_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} edd_cfg_t;

	// clamp a wide signed value to the signed range of eb bits
	function automatic logic signed [63:0] sat_wide(input logic signed [63:0] x,
			input int unsigned eb);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (eb - 1)) - 64'sd1;
		lo = -(64'sd1 <<< (eb - 1));
		if (x > hi) begin
			return hi;
		end else if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

endpackage

>>> rtl/core/edd_stream_if.sv
// ----------------------------------------------------------------------------
// edd_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface edd_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

>>> rtl/core/edd_contrib.sv
// ----------------------------------------------------------------------------
// edd_contrib
// one diffusion lane: error times weight, rounded to the error format
// ----------------------------------------------------------------------------
module edd_contrib #(
	parameter int ERR_BITS = edd_pkg::FRAC_BITS_DEF + 4
) (
	input  logic                       clk,
	input  logic                       ld,
	input  logic signed [ERR_BITS-1:0] err,
	input  logic signed [edd_pkg::WT_W-1:0] weight,
	output logic signed [ERR_BITS-1:0] contrib
);

	localparam int SPLIT = edd_pkg::WT_SPLIT;
	localparam int WTW   = edd_pkg::WT_W;
	localparam int PL_W  = ERR_BITS + SPLIT + 1;
	localparam int PH_W  = ERR_BITS + WTW - SPLIT;
	localparam int SUM_W = ERR_BITS + WTW + 1;
	localparam int SH    = edd_pkg::WFRAC + 4;

	localparam logic signed [SUM_W-1:0] RND_V = SUM_W'(64'sd1 <<< (SH - 1));

	logic signed [PL_W-1:0]  pl_s1;
	logic signed [PH_W-1:0]  ph_s1;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-SH-1:0] quo;

	// two partial products, low weight half taken as unsigned
	always_ff @(posedge clk) begin
		if (ld) begin
			pl_s1 <= err * $signed({1'b0, weight[SPLIT-1:0]});
			ph_s1 <= err * $signed(weight[WTW-1:SPLIT]);
		end
	end

	// recombine, round half up, floor shift and saturate
	always_comb begin
		sum     = (SUM_W'(ph_s1) <<< SPLIT) + SUM_W'(pl_s1) + RND_V;
		quo     = $signed(sum[SUM_W-1:SH]);
		contrib = ERR_BITS'(edd_pkg::sat_wide(64'(quo), ERR_BITS));
	end

endmodule

>>> rtl/core/error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither
// one-bit error diffusion dither with serpentine order and jittered weights
// ----------------------------------------------------------------------------
// A pixel occupies the block from its transfer through the DIFF, MUL and UPD states
// (and WLAST on the last pixel of a row), and its result is loaded into the output
// register as UPD completes: the error line store is a single-port memory with a
// registered read, so each pixel reads its entry, forms and thresholds the error,
// multiplies it by the four weights in a registered stage, then writes back the
// finished error of the pixel behind (and, in the following cycle at row end, of the
// last pixel). The next pixel is taken only once this read-modify-write is done.
// After reset and on every pixel flagged as frame start the line store is swept to
// zero, all MAX_WIDTH entries, during which no pixel is taken (a frame start pixel
// then issues its read in ISSUE after the sweep); configuration writes are always
// taken. A finished result waits in an output register, so a stalled consumer holds
// up the block only when the following result is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module error_diffusion_dither #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF,
	parameter int FRAC_BITS = edd_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	edd_stream_if.sink     pixel_in,
	edd_stream_if.source   pixel_out,
	edd_stream_if.sink     cfg
);

	localparam int EB   = FRAC_BITS + 4;
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int IWW  = edd_pkg::IMG_W_W;
	localparam int CMPW = (WW > IWW) ? WW : IWW;
	localparam int WTW  = edd_pkg::WT_W;
	localparam int JPW  = edd_pkg::JP_W;

	localparam logic signed [EB-1:0]  ONE_V  = EB'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [EB-1:0]  HALF_V = EB'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [WTW-1:0] W7_V   = WTW'(64'sd7 <<< edd_pkg::WFRAC);
	localparam logic signed [WTW-1:0] W3_V   = WTW'(64'sd3 <<< edd_pkg::WFRAC);
	localparam logic signed [WTW-1:0] W5_V   = WTW'(64'sd5 <<< edd_pkg::WFRAC);
	localparam logic signed [WTW-1:0] W1_V   = WTW'(64'sd1 <<< edd_pkg::WFRAC);

	edd_pkg::edd_state_t state_q, state_d;

	// configuration registers
	logic [IWW-1:0] image_width_q;
	logic           serp_off_q;
	logic           fixed_w_q;
	logic [15:0]    jscale_q;

	// row state
	logic [AW-1:0]        col_q;
	logic                 odd_q;
	logic signed [EB-1:0] ahead_q;
	logic signed [EB-1:0] pbl_q;
	logic signed [EB-1:0] pb_q;

	// sweep control
	logic [AW-1:0] clr_addr_q;
	logic          pend_q;

	// pixel pipeline
	logic [15:0]           sample_q;
	logic signed [JPW-1:0] jp_a_s1;
	logic signed [JPW-1:0] jp_b_s1;
	logic [AW-1:0]         x_s1;
	logic [AW-1:0]         behind_s1;
	logic                  behind_ok_s1;
	logic                  last_s1;
	logic [AW-1:0]         col_eff_s1;
	logic signed [EB-1:0]  rd_q;
	logic signed [EB-1:0]  e_s2;
	logic                  white_s2;
	logic signed [WTW-1:0] w7_s2, w3_s2, w5_s2, w1_s2;
	logic signed [EB-1:0]  c7, c3, c5, c1;

	// output register
	logic out_valid_q;
	logic out_pix_q;
	logic out_end_q;

	// line store
	logic [EB-1:0] mem [MAX_WIDTH];

	// combinational
	logic [CMPW-1:0]       iw;
	logic [WW-1:0]         w_eff;
	logic [AW-1:0]         wm1;
	logic [AW-1:0]         col_eff;
	logic                  last_c;
	logic                  rev_c;
	logic [AW-1:0]         x_c;
	logic [AW-1:0]         behind_c;
	logic                  behind_ok_c;
	logic [FRAC_BITS+15:0] s_wide;
	logic [FRAC_BITS-1:0]  s_val;
	logic signed [EB-1:0]  value_c;
	logic                  white_c;
	logic signed [EB-1:0]  e_c;
	logic signed [WTW-1:0] t75, t31;
	logic signed [EB-1:0]  pbl_new;
	logic signed [EB-1:0]  pbl_next;

	logic          in_ready;
	logic          in_fire;
	logic          cfg_fire;
	logic          out_free;
	logic          rd_en;
	logic          upd_fire;
	logic          mul_ld;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EB-1:0] mem_wdata;

	assign pixel_in.ready = in_ready;
	assign in_fire        = pixel_in.valid && in_ready;
	assign cfg.ready      = 1'b1;
	assign cfg_fire       = cfg.valid;
	assign out_free       = !out_valid_q || pixel_out.ready;

	assign pixel_out.valid          = out_valid_q;
	assign pixel_out.data.pixel_bit = out_pix_q;
	assign pixel_out.data.row_end   = out_end_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= edd_pkg::IMAGE_WIDTH_RST;
			serp_off_q    <= 1'b1;
			fixed_w_q     <= 1'b1;
			jscale_q      <= '0;
		end else if (cfg_fire) begin
			case (cfg.data.index)
				edd_pkg::CFG_IMAGE_WIDTH:    image_width_q <= cfg.data.value[IWW-1:0];
				edd_pkg::CFG_SERPENTINE_OFF: serp_off_q    <= cfg.data.value[0];
				edd_pkg::CFG_FIXED_WEIGHTS:  fixed_w_q     <= cfg.data.value[0];
				edd_pkg::CFG_JITTER_SCALE:   jscale_q      <= cfg.data.value;
				default: begin
				end
			endcase
		end
	end

	// effective width, column and position in the row
	always_comb begin
		iw = CMPW'(image_width_q);
		if (iw == '0) begin
			w_eff = WW'(1);
		end else if (iw > CMPW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(iw);
		end
		wm1         = AW'(w_eff - WW'(1));
		last_c      = (col_q >= wm1);
		col_eff     = last_c ? wm1 : col_q;
		rev_c       = !serp_off_q && odd_q;
		x_c         = rev_c ? (wm1 - col_eff) : col_eff;
		behind_c    = rev_c ? (x_c + AW'(1)) : (x_c - AW'(1));
		behind_ok_c = rev_c ? (x_c < wm1) : (x_c != '0);
	end

	// diffused sum, threshold and residual error
	always_comb begin
		s_wide  = {sample_q, {FRAC_BITS{1'b0}}} >> 16;
		s_val   = s_wide[FRAC_BITS-1:0];
		value_c = EB'(edd_pkg::sat_wide($signed(64'(s_val)) + 64'(rd_q) + 64'(ahead_q), EB));
		white_c = (value_c > HALF_V);
		e_c     = EB'(edd_pkg::sat_wide(64'(value_c) - (white_c ? 64'(ONE_V) : 64'sd0), EB));
		t75     = fixed_w_q ? '0 : ((WTW'(jp_a_s1) <<< 2) + WTW'(jp_a_s1));
		t31     = fixed_w_q ? '0 : WTW'(jp_b_s1);
	end

	// error sums for the row below
	always_comb begin
		pbl_new  = EB'(edd_pkg::sat_wide(64'(pbl_q) + 64'(c3), EB));
		pbl_next = EB'(edd_pkg::sat_wide(64'(pb_q) + 64'(c5), EB));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			edd_pkg::ST_CLEAR: begin
				if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
					state_d = pend_q ? edd_pkg::ST_ISSUE : edd_pkg::ST_IDLE;
				end
			end
			edd_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = pixel_in.data.frame_start ? edd_pkg::ST_CLEAR : edd_pkg::ST_DIFF;
				end
			end
			edd_pkg::ST_ISSUE: state_d = edd_pkg::ST_DIFF;
			edd_pkg::ST_DIFF:  state_d = edd_pkg::ST_MUL;
			edd_pkg::ST_MUL:   state_d = edd_pkg::ST_UPD;
			edd_pkg::ST_UPD: begin
				if (out_free) begin
					state_d = last_s1 ? edd_pkg::ST_WLAST : edd_pkg::ST_IDLE;
				end
			end
			edd_pkg::ST_WLAST: state_d = edd_pkg::ST_IDLE;
			default:           state_d = edd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs and line store write port
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		upd_fire  = 1'b0;
		mul_ld    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		case (state_q)
			edd_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			edd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = pixel_in.valid && !pixel_in.data.frame_start;
			end
			edd_pkg::ST_ISSUE: begin
				rd_en = 1'b1;
			end
			edd_pkg::ST_MUL: begin
				mul_ld = 1'b1;
			end
			edd_pkg::ST_UPD: begin
				upd_fire  = out_free;
				mem_we    = out_free && behind_ok_s1;
				mem_waddr = behind_s1;
				mem_wdata = pbl_new;
			end
			edd_pkg::ST_WLAST: begin
				mem_we    = 1'b1;
				mem_waddr = x_s1;
				mem_wdata = pbl_q;
			end
			default: begin
			end
		endcase
	end

	// state register and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= edd_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			pend_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == edd_pkg::ST_CLEAR) begin
				if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
					clr_addr_q <= '0;
					pend_q     <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
			end else if (in_fire && pixel_in.data.frame_start) begin
				pend_q <= 1'b1;
			end
		end
	end

	// row state: errors carried along the row, column and row parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			odd_q   <= 1'b0;
			ahead_q <= '0;
			pbl_q   <= '0;
			pb_q    <= '0;
		end else if (in_fire && pixel_in.data.frame_start) begin
			col_q   <= '0;
			odd_q   <= 1'b0;
			ahead_q <= '0;
			pbl_q   <= '0;
			pb_q    <= '0;
		end else if (upd_fire) begin
			pbl_q   <= pbl_next;
			pb_q    <= last_s1 ? '0 : c1;
			ahead_q <= last_s1 ? '0 : c7;
			col_q   <= last_s1 ? '0 : (col_eff_s1 + AW'(1));
			odd_q   <= odd_q ^ last_s1;
		end else if (state_q == edd_pkg::ST_WLAST) begin
			pbl_q <= '0;
		end
	end

	// sample and jitter products at transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= pixel_in.data.sample;
			jp_a_s1  <= pixel_in.data.jitter_a * $signed({1'b0, jscale_q});
			jp_b_s1  <= pixel_in.data.jitter_b * $signed({1'b0, jscale_q});
		end
	end

	// line store read and pixel position
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q         <= $signed(mem[x_c]);
			x_s1         <= x_c;
			behind_s1    <= behind_c;
			behind_ok_s1 <= behind_ok_c;
			last_s1      <= last_c;
			col_eff_s1   <= col_eff;
		end
	end

	// line store write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// residual error and weights
	always_ff @(posedge clk) begin
		if (state_q == edd_pkg::ST_DIFF) begin
			e_s2     <= e_c;
			white_s2 <= white_c;
			w7_s2    <= W7_V + t75;
			w5_s2    <= W5_V - t75;
			w3_s2    <= W3_V + t31;
			w1_s2    <= W1_V - t31;
		end
	end

	// four diffusion lanes
	edd_contrib #(.ERR_BITS(EB)) u_c7 (
		.clk(clk), .ld(mul_ld), .err(e_s2), .weight(w7_s2), .contrib(c7)
	);
	edd_contrib #(.ERR_BITS(EB)) u_c3 (
		.clk(clk), .ld(mul_ld), .err(e_s2), .weight(w3_s2), .contrib(c3)
	);
	edd_contrib #(.ERR_BITS(EB)) u_c5 (
		.clk(clk), .ld(mul_ld), .err(e_s2), .weight(w5_s2), .contrib(c5)
	);
	edd_contrib #(.ERR_BITS(EB)) u_c1 (
		.clk(clk), .ld(mul_ld), .err(e_s2), .weight(w1_s2), .contrib(c1)
	);

	// result register, held until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (pixel_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_pix_q <= white_s2;
			out_end_q <= last_s1;
		end
	end

	// checks
	`ASSERT_AT(a_frame_start_sweeps, in_fire && pixel_in.data.frame_start |=> state_q == edd_pkg::ST_CLEAR, "frame start did not begin the line store sweep")
	`ASSERT_AT(a_row_end_write, state_q == edd_pkg::ST_WLAST |-> $past(state_q) == edd_pkg::ST_UPD && last_s1, "row end write without a finished last pixel")
	`ASSERT_NEVER(a_behind_in_row, state_q == edd_pkg::ST_UPD && mem_we && behind_s1 > wm1, "behind write outside the row")
	`ASSERT_AT(a_result_from_update, $rose(out_valid_q) |-> $past(state_q) == edd_pkg::ST_UPD, "result appeared outside the update step")

endmodule
